// ===== hw/rtl/cc20_pkg.sv =====
// Shared types and constants for the ChaCha20 stream cipher.
package cc20_pkg;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam int NUM_REGS = 7;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_KEY0   = 3'd0;
	localparam logic [2:0] REG_KEY1   = 3'd1;
	localparam logic [2:0] REG_KEY2   = 3'd2;
	localparam logic [2:0] REG_KEY3   = 3'd3;
	localparam logic [2:0] REG_NONCE0 = 3'd4;
	localparam logic [2:0] REG_NONCE1 = 3'd5;
	localparam logic [2:0] REG_CTR    = 3'd6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // copy the input state into the working words
		logic col;       // run one column round
		logic diag;      // run one diagonal round
		logic finish;    // feed-forward add into the keystream buffer
	} cc20_cmd_t;

	function automatic logic [31:0] rol(input logic [31:0] v, input int s);
		rol = (v << s) | (v >> (32 - s));
	endfunction

	// One full quarter-round on four words.
	function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] ta, tb, tc, td;
		ta = a + b; td = rol(d ^ ta, 16);
		tc = c + td; tb = rol(b ^ tc, 12);
		ta = ta + tb; td = rol(td ^ ta, 8);
		tc = tc + td; tb = rol(tb ^ tc, 7);
		qr = {td, tc, tb, ta};
	endfunction

endpackage

// ===== hw/rtl/cc20_datapath.sv =====
// Round datapath: working words, input state and keystream buffer.
module cc20_datapath import cc20_pkg::*; (
	input  logic         clk,
	input  cc20_cmd_t    cmd,
	input  logic [255:0] key,
	input  logic [95:0]  nonce,
	input  logic [31:0]  counter,
	input  logic [5:0]   rd_pos,
	output logic [7:0]   ks_byte
);

	logic [31:0] w_q [16];
	logic [31:0] init_q [16];
	logic [31:0] ks_q [16];
	logic [31:0] nw [16];

	// Column or diagonal round on the working words.
	always_comb begin
		logic [127:0] r;
		for (int i = 0; i < 16; i++) nw[i] = w_q[i];
		for (int i = 0; i < 4; i++) begin
			if (cmd.col) begin
				r = qr(w_q[i], w_q[4 + i], w_q[8 + i], w_q[12 + i]);
				nw[i] = r[31:0]; nw[4 + i] = r[63:32];
				nw[8 + i] = r[95:64]; nw[12 + i] = r[127:96];
			end else begin
				r = qr(w_q[i], w_q[4 + (i + 1) % 4], w_q[8 + (i + 2) % 4],
					w_q[12 + (i + 3) % 4]);
				nw[i] = r[31:0]; nw[4 + (i + 1) % 4] = r[63:32];
				nw[8 + (i + 2) % 4] = r[95:64]; nw[12 + (i + 3) % 4] = r[127:96];
			end
		end
	end

	// Working state, input state and keystream buffer updates.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			init_q[0] <= SIGMA0; init_q[1] <= SIGMA1;
			init_q[2] <= SIGMA2; init_q[3] <= SIGMA3;
			w_q[0] <= SIGMA0; w_q[1] <= SIGMA1; w_q[2] <= SIGMA2; w_q[3] <= SIGMA3;
			for (int i = 0; i < 8; i++) begin
				init_q[4 + i] <= key[32 * i +: 32];
				w_q[4 + i] <= key[32 * i +: 32];
			end
			init_q[12] <= counter; w_q[12] <= counter;
			for (int i = 0; i < 3; i++) begin
				init_q[13 + i] <= nonce[32 * i +: 32];
				w_q[13 + i] <= nonce[32 * i +: 32];
			end
		end else if (cmd.col || cmd.diag) begin
			for (int i = 0; i < 16; i++) w_q[i] <= nw[i];
		end
		// The keystream block is kept as 16 little-endian words.
		if (cmd.finish) begin
			for (int i = 0; i < 16; i++) ks_q[i] <= w_q[i] + init_q[i];
		end
	end

	// Byte select within the addressed keystream word.
	assign ks_byte = ks_q[rd_pos[5:2]][8 * rd_pos[1:0] +: 8];

endmodule

// ===== hw/rtl/cc20_ctrl.sv =====
// Controller: message tracking, block sequencing and output register.
module cc20_ctrl import cc20_pkg::*; #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_data,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_data,
	output logic        out_last,
	input  logic [31:0] start_counter,
	output cc20_cmd_t   cmd,
	output logic [31:0] counter,
	output logic [5:0]  rd_pos,
	input  logic [7:0]  ks_byte
);

	localparam int RW = $clog2(2 * DOUBLE_ROUNDS);

	typedef enum logic [2:0] {IDLE, LOAD, ROUND, FINISH, EMIT} state_t;

	state_t      state_q;
	logic [RW-1:0] rnd_q;
	logic [31:0] ctr_q;
	logic [5:0]  pos_q;
	logic        open_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic        ovalid_q;
	logic [7:0]  odata_q;
	logic        olast_q;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;
	assign out_last  = olast_q;
	assign rd_pos    = pos_q;
	assign counter   = ctr_q;

	always_comb begin
		cmd = '0;
		cmd.load   = (state_q == LOAD);
		cmd.col    = (state_q == ROUND) && !rnd_q[0];
		cmd.diag   = (state_q == ROUND) && rnd_q[0];
		cmd.finish = (state_q == FINISH);
	end

	// Sequencer: accept a byte, refill the block when needed, then emit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			rnd_q    <= '0;
			ctr_q    <= '0;
			pos_q    <= '0;
			open_q   <= 1'b0;
			data_q   <= '0;
			last_q   <= 1'b0;
			ovalid_q <= 1'b0;
			odata_q  <= '0;
			olast_q  <= 1'b0;
		end else begin
			// The output beat is loaded in EMIT and dropped once taken.
			if (state_q == EMIT && (!ovalid_q || out_ready)) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				IDLE: if (in_valid) begin
					data_q <= in_data;
					last_q <= in_last;
					open_q <= 1'b1;
					if (!open_q) begin
						ctr_q <= start_counter;
						pos_q <= '0;
						state_q <= LOAD;
					end else if (pos_q == '0) begin
						state_q <= LOAD;
					end else begin
						state_q <= EMIT;
					end
				end
				LOAD: begin
					rnd_q <= '0;
					state_q <= ROUND;
				end
				ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RW'(2 * DOUBLE_ROUNDS - 1)) state_q <= FINISH;
				end
				FINISH: begin
					ctr_q <= ctr_q + 32'd1;
					state_q <= EMIT;
				end
				EMIT: if (!ovalid_q || out_ready) begin
					odata_q  <= data_q ^ ks_byte;
					olast_q  <= last_q;
					pos_q    <= pos_q + 6'd1;
					if (last_q) open_q <= 1'b0;
					state_q  <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/chacha20_stream_cipher_top.sv =====
// Top level of the byte-serial ChaCha20 stream cipher.
// Each accepted byte is XORed with the next keystream byte; a byte that
// needs no new block is accepted, then loaded into the output register
// once the output is free. A byte at block position 0 also runs the
// round sequencer: a load step, then alternating column and diagonal
// rounds (one full round per cycle), then a feed-forward step.
// Key and nonce changes apply at the next block.
module chacha20_stream_cipher_top import cc20_pkg::*; #(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tlast,  // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // result_byte
	output logic        m_axis_tlast,  // result_last
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] key_q [4];
	logic [63:0] nonce0_q;
	logic [31:0] nonce1_q;
	logic [31:0] sctr_q;
	cc20_cmd_t   cmd;
	logic [31:0] counter;
	logic [5:0]  rd_pos;
	logic [7:0]  ks_byte;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			nonce0_q <= '0;
			nonce1_q <= '0;
			sctr_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY0:   key_q[0] <= cfg_data;
				REG_KEY1:   key_q[1] <= cfg_data;
				REG_KEY2:   key_q[2] <= cfg_data;
				REG_KEY3:   key_q[3] <= cfg_data;
				REG_NONCE0: nonce0_q <= cfg_data;
				REG_NONCE1: nonce1_q <= cfg_data[31:0];
				REG_CTR:    sctr_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	cc20_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata), .in_last(s_axis_tlast),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata), .out_last(m_axis_tlast),
		.start_counter(sctr_q), .cmd, .counter, .rd_pos, .ks_byte
	);

	cc20_datapath u_dp (
		.clk, .cmd,
		.key({key_q[3], key_q[2], key_q[1], key_q[0]}),
		.nonce({nonce1_q, nonce0_q}),
		.counter, .rd_pos, .ks_byte
	);

	// Only one datapath command is active at a time.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.col, cmd.diag, cmd.finish}))
		else $error("datapath commands overlap");

	// A result beat that waits keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// No input is taken while a block is being generated.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.col || cmd.diag) |-> !s_axis_tready)
		else $error("input accepted during rounds");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the byte-serial ChaCha20 stream cipher.
`timescale 1ns / 100ps

module tb_top import cc20_pkg::*;;

	localparam int DOUBLE_ROUNDS = 10;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} cipher_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	chacha20_stream_cipher_top #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow of the cipher's registers and stream state.
	logic [63:0] shadow_regs [NUM_REGS];
	logic [7:0]  ks_block [64];
	logic [5:0]  ks_pos;
	logic [31:0] ks_counter;
	logic        msg_open;

	cipher_beat_t expected_bytes [$];
	int errors;
	int cycle_count;
	int sent_count;
	int recv_count;
	int msg_count;
	int send_idle_pct;
	int recv_idle_pct;
	bit recv_hold;

	function automatic logic [31:0] rotl32(logic [31:0] v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic void mix_quarter(ref logic [31:0] w[16], input int a, int b, int c, int d);
		w[a] += w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
		w[c] += w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
		w[a] += w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
		w[c] += w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
	endfunction

	// Build a 64-byte keystream block from the shadow registers and counter.
	function automatic void build_keystream();
		logic [31:0] seed [16];
		logic [31:0] w [16];
		logic [31:0] v;
		seed[0] = SIGMA0; seed[1] = SIGMA1; seed[2] = SIGMA2; seed[3] = SIGMA3;
		for (int i = 0; i < 8; i++)
			seed[4 + i] = shadow_regs[i >> 1][32 * (i & 1) +: 32];
		seed[12] = ks_counter;
		seed[13] = shadow_regs[REG_NONCE0][31:0];
		seed[14] = shadow_regs[REG_NONCE0][63:32];
		seed[15] = shadow_regs[REG_NONCE1][31:0];
		w = seed;
		for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
			mix_quarter(w, 0, 4, 8, 12);
			mix_quarter(w, 1, 5, 9, 13);
			mix_quarter(w, 2, 6, 10, 14);
			mix_quarter(w, 3, 7, 11, 15);
			mix_quarter(w, 0, 5, 10, 15);
			mix_quarter(w, 1, 6, 11, 12);
			mix_quarter(w, 2, 7, 8, 13);
			mix_quarter(w, 3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++) begin
			v = w[i] + seed[i];
			for (int b = 0; b < 4; b++)
				ks_block[4 * i + b] = v[8 * b +: 8];
		end
	endfunction

	// Work out the ciphertext beat that one accepted byte produces.
	function automatic cipher_beat_t encrypt_byte(cipher_beat_t in_beat);
		cipher_beat_t out_beat;
		if (!msg_open) begin
			ks_counter = shadow_regs[REG_CTR][31:0];
			ks_pos = '0;
			msg_open = 1'b1;
		end
		if (ks_pos == 0) begin
			build_keystream();
			ks_counter = ks_counter + 32'd1;
		end
		out_beat.data = in_beat.data ^ ks_block[ks_pos];
		out_beat.last = in_beat.last;
		ks_pos = ks_pos + 6'd1;
		if (in_beat.last)
			msg_open = 1'b0;
		return out_beat;
	endfunction

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("chacha20_stream_cipher_top regression: fail");
			$finish;
		end
	end

	// Receiver: random back-pressure, a long hold-off when asked.
	always @(posedge clk) begin
		if (!arst_n || recv_hold)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Check each accepted result beat against the oldest expectation.
	always @(posedge clk) begin
		cipher_beat_t exp_beat;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			recv_count <= recv_count + 1;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected beat: actual data=%02h last=%0b", $time,
					m_axis_tdata, m_axis_tlast);
				errors++;
			end else begin
				exp_beat = expected_bytes.pop_front();
				if (exp_beat.data !== m_axis_tdata || exp_beat.last !== m_axis_tlast) begin
					$display("%0t: mismatch: expected data=%02h last=%0b, actual data=%02h last=%0b",
						$time, exp_beat.data, exp_beat.last, m_axis_tdata, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// Write one register while the block is idle.
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < NUM_REGS)
			shadow_regs[idx] = (idx >= REG_NONCE1) ? {32'd0, val[31:0]} : val;
	endtask

	// Offer one byte and wait until it is accepted; valid drops only while idling.
	task automatic send_byte(logic [7:0] data, logic last, bit may_idle);
		cipher_beat_t in_beat;
		while (may_idle && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tlast <= last;
		in_beat.data = data;
		in_beat.last = last;
		do @(posedge clk); while (!s_axis_tready);
		expected_bytes.push_back(encrypt_byte(in_beat));
		sent_count++;
		if (last)
			msg_count++;
	endtask

	// Wait until every expected beat has come back, then let the sequencer settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Random configuration, with extremes now and then.
	task automatic random_config();
		logic [63:0] val;
		for (int r = 0; r < NUM_REGS; r++) begin
			case ($urandom_range(3))
				0: val = '0;
				1: val = '1;
				default: val = {$urandom, $urandom};
			endcase
			if (r == REG_CTR && $urandom_range(2) == 0)
				val = 64'hFFFF_FFFF - $urandom_range(2);
			write_reg(r[2:0], val);
		end
	endtask

	// Random messages, mostly short, a few spanning several blocks.
	task automatic random_traffic(int n_bytes);
		int msg_len;
		int done;
		done = 0;
		while (done < n_bytes) begin
			msg_len = ($urandom_range(9) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 70);
			for (int i = 0; i < msg_len && done < n_bytes; i++) begin
				send_byte($urandom_range(255), (i == msg_len - 1), 1'b1);
				done++;
			end
		end
	endtask

	// Directed stimulus table: data, last.
	localparam int DIR_ROWS = 22;
	cipher_beat_t dir_table [DIR_ROWS] = '{
		'{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'h55, 1'b0}, '{8'hAA, 1'b1},
		'{8'h00, 1'b1}, '{8'hFF, 1'b1}, '{8'h01, 1'b0}, '{8'h80, 1'b0},
		'{8'h7F, 1'b0}, '{8'hFE, 1'b1}, '{8'h00, 1'b0}, '{8'h00, 1'b0},
		'{8'h00, 1'b0}, '{8'h00, 1'b1}, '{8'h12, 1'b0}, '{8'h34, 1'b1},
		'{8'hC3, 1'b0}, '{8'h3C, 1'b0}, '{8'hF0, 1'b0}, '{8'h0F, 1'b1},
		'{8'hFF, 1'b0}, '{8'h00, 1'b1}
	};

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sent_count = 0;
		msg_count = 0;
		recv_hold = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int r = 0; r < NUM_REGS; r++)
			shadow_regs[r] = '0;
		ks_pos = '0;
		ks_counter = '0;
		msg_open = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reset values first, then all-ones and counter wrap.
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == 6) begin
				drain();
				for (int r = 0; r < NUM_REGS; r++)
					write_reg(r[2:0], '1);
				// An index past the last register must be ignored.
				write_reg(3'd7, 64'h0123_4567_89AB_CDEF);
			end
			if (i == 14) begin
				drain();
				write_reg(REG_CTR, 64'h0000_0000_FFFF_FFFF);
				write_reg(REG_KEY2, 64'h0706_0504_0302_0100);
			end
			send_byte(dir_table[i].data, dir_table[i].last, 1'b0);
		end
		// Long message across the counter wrap, with a nonce change mid-message.
		for (int i = 0; i < 70; i++)
			send_byte($urandom_range(255), 1'b0, 1'b0);
		drain();
		write_reg(REG_NONCE0, 64'hDEAD_BEEF_0000_0001);
		for (int i = 0; i < 60; i++)
			send_byte($urandom_range(255), (i == 59), 1'b0);
		drain();

		// Random phases with the idling mixes.
		send_idle_pct = 30; recv_idle_pct = 61;
		random_config();
		random_traffic(200);
		drain();
		send_idle_pct = 61; recv_idle_pct = 30;
		random_config();
		random_traffic(200);
		drain();
		send_idle_pct = 0; recv_idle_pct = 0;
		random_config();
		fork
			begin
				recv_hold = 1'b1;
				repeat (400) @(posedge clk);
				recv_hold = 1'b0;
			end
			begin
				random_traffic(200);
				s_axis_tvalid <= 1'b0;
			end
		join
		drain();
		write_reg(REG_CTR, 64'd0);
		random_traffic(100);
		s_axis_tvalid <= 1'b0;

		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d bytes in %0d messages, %0d checked;", sent_count, msg_count,
			recv_count);
		$display("covered reset keys, all-ones registers, counter wrap and back-pressure.");
		if (errors == 0 && expected_bytes.size() == 0)
			$display("chacha20_stream_cipher_top regression: pass");
		else
			$display("chacha20_stream_cipher_top regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/cc20_pkg.sv
hw/rtl/cc20_datapath.sv
hw/rtl/cc20_ctrl.sv
hw/rtl/chacha20_stream_cipher_top.sv
verif/tb_top.sv
